### rtl/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; imported by hcbd_core and the top level.
`default_nettype none

package hcbd_pkg;

  // Default counter width for the chunk size field
  localparam int unsigned SIZE_BITS_DEFAULT = 32;

  // Reset value of the extension gap limit register
  localparam logic [7:0] GAP_LIMIT_RESET = 8'd10;

  // Line delimiters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Outcome of parsing one byte; emit marks that a result transaction is due
  typedef struct packed {
    logic       emit;
    logic       parse_error;
    logic       message_end;
    logic       is_data;
    logic [7:0] data_byte;
  } hcbd_result_t;

endpackage

`default_nettype wire

### rtl/hcbd_core.sv
// Chunked-body parser state and per-byte next-state logic.
// Depends on hcbd_pkg (result struct, CR/LF codes).
`default_nettype none

module hcbd_core #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 sob_i,
  input  wire logic [7:0]           gap_limit_i,
  output hcbd_pkg::hcbd_result_t    result_o
);
  import hcbd_pkg::*;

  typedef enum logic [7:0] {
    PH_SIZE    = 8'b0000_0001,
    PH_EXT     = 8'b0000_0010,
    PH_SIZE_LF = 8'b0000_0100,
    PH_DATA    = 8'b0000_1000,
    PH_TRL_CR  = 8'b0001_0000,
    PH_TRL_LF  = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_e;

  phase_e               phase_q, phase_d, phase_cur;
  logic [SIZE_BITS-1:0] rem_q, rem_d, rem_cur;
  logic [7:0]           gap_q, gap_d, gap_cur, gap_inc;
  logic                 seen_q, seen_d, seen_cur;
  logic                 hex_ok;
  logic [3:0]           hex_val;
  hcbd_result_t         res;

  // {valid, nibble} for an ASCII hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  assign {hex_ok, hex_val} = hex_decode(byte_i);

  // start of body restarts the parser ahead of this byte
  assign phase_cur = sob_i ? PH_SIZE : phase_q;
  assign rem_cur   = sob_i ? '0 : rem_q;
  assign gap_cur   = sob_i ? 8'd0 : gap_q;
  assign seen_cur  = sob_i ? 1'b0 : seen_q;
  assign gap_inc   = gap_cur + 8'd1;

  always_comb begin
    phase_d = phase_cur;
    rem_d   = rem_cur;
    gap_d   = gap_cur;
    seen_d  = seen_cur;
    res     = '0;
    unique case (phase_cur)
      PH_SIZE: begin
        if (hex_ok) begin
          if (rem_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_d = PH_ERROR;   // size overflow
            res.parse_error = 1'b1;
            res.emit = 1'b1;
          end else begin
            rem_d  = {rem_cur[SIZE_BITS-5:0], hex_val};
            seen_d = 1'b1;
          end
        end else if (!seen_cur) begin
          phase_d = PH_ERROR;     // no digit on the size line
          res.parse_error = 1'b1;
          res.emit = 1'b1;
        end else if (byte_i == CHAR_CR) begin
          gap_d   = 8'd0;
          phase_d = PH_SIZE_LF;
        end else if (gap_limit_i == 8'd0) begin
          phase_d = PH_ERROR;
          res.parse_error = 1'b1;
          res.emit = 1'b1;
        end else begin
          gap_d   = 8'd1;
          phase_d = PH_EXT;
        end
      end
      PH_EXT: begin
        if (byte_i == CHAR_CR) begin
          phase_d = PH_SIZE_LF;
        end else if (gap_cur >= gap_limit_i) begin
          phase_d = PH_ERROR;
          res.parse_error = 1'b1;
          res.emit = 1'b1;
        end else begin
          gap_d = gap_inc;
        end
      end
      PH_SIZE_LF: begin
        if (byte_i == CHAR_LF) begin
          seen_d = 1'b0;
          gap_d  = 8'd0;
          if (rem_cur == '0) begin
            phase_d = PH_DONE;
            res.message_end = 1'b1;
            res.emit = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end else if (gap_cur >= gap_limit_i) begin
          phase_d = PH_ERROR;
          res.parse_error = 1'b1;
          res.emit = 1'b1;
        end else if (byte_i == CHAR_CR) begin
          // stray CR counts once, the new CR waits for its LF
          gap_d = gap_inc;
        end else if (gap_inc >= gap_limit_i) begin
          // stray CR plus this byte both count as extension
          phase_d = PH_ERROR;
          res.parse_error = 1'b1;
          res.emit = 1'b1;
        end else begin
          gap_d   = gap_inc + 8'd1;
          phase_d = PH_EXT;
        end
      end
      PH_DATA: begin
        rem_d = rem_cur - SIZE_BITS'(1);
        if (rem_cur == SIZE_BITS'(1)) begin
          phase_d = PH_TRL_CR;
        end
        res.data_byte = byte_i;
        res.is_data   = 1'b1;
        res.emit      = 1'b1;
      end
      PH_TRL_CR: begin
        phase_d = PH_TRL_LF;
      end
      PH_TRL_LF: begin
        phase_d = PH_SIZE;
        rem_d   = '0;
        gap_d   = 8'd0;
        seen_d  = 1'b0;
      end
      default: begin
        // done or failed: hold until the next start of body
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      rem_q   <= '0;
      gap_q   <= 8'd0;
      seen_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      gap_q   <= gap_d;
      seen_q  <= seen_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

### rtl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder: stream ports, input and
// result registers, config register. Depends on hcbd_pkg and hcbd_core.
//
//  channel | direction | tdata / data          | tuser                          | sideband
//  --------+-----------+-----------------------+--------------------------------+---------
//  s_axis  | in        | [7:0] in_byte         | [0] start_of_body              | -
//  m_axis  | out       | [7:0] data_byte       | [0] is_data [1] message_end    | -
//          |           |                       | [2] parse_error                |
//  cfg     | in        | [7:0] ext. gap limit  | -                              | -
//
// One byte per cycle sustained while the output is not stalled. A byte is
// registered on acceptance, parsed from the input register, and its result
// is registered. Chunk size, gap count and phase update once per parsed byte;
// bytes that produce no result leave the output alone. Reset puts the parser at
// "waiting for a size line" and the gap limit at 10. A stalled output holds its
// transaction; the input then takes one more byte and stalls until it drains.
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic [0:0] s_axis_tuser_i,   // [0] start_of_body
  // result stream
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] data_byte
  output logic [2:0]      m_axis_tuser_o,   // [0] is_data [1] message_end [2] parse_error
  // config write
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i        // extension gap limit
);
  import hcbd_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_sob_q;
  logic         out_valid_q;
  logic [7:0]   out_data_q;
  logic [2:0]   out_flags_q;
  logic [7:0]   gap_limit_q;
  logic         advance;
  hcbd_result_t result;

  // parse when a byte is staged and the result register is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= GAP_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      gap_limit_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_sob_q  <= s_axis_tuser_i[0];
    end
  end

  hcbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .sob_i      (in_sob_q),
    .gap_limit_i(gap_limit_q),
    .result_o   (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.emit) begin
      out_data_q  <= result.data_byte;
      out_flags_q <= {result.parse_error, result.message_end, result.is_data};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_flags_q;

endmodule

`default_nettype wire

### rtl/hcbd_checker.sv
// Port-level checks for http_chunked_body_decoder, bound to the top level.
// No package dependencies.
`default_nettype none

module hcbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [2:0] m_axis_tuser_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // each result is exactly one of data, end or error
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot(m_axis_tuser_o))
    else $error("result kind not one-hot");

  // non-data results carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 8'd0)
    else $error("non-data result with nonzero byte");

  // empty result register never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

`default_nettype wire
